// ===== hdl/a256x2_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// a256x2_pkg
// Shared types, request codes and the AES round function for the state block.
// ----------------------------------------------------------------------------
package a256x2_pkg;

    localparam int NUM_WORDS  = 24;
    localparam int NUM_BLOCKS = 6;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    typedef logic [63:0] t_word;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // one zero-key AES round on a lane held little-endian in 128 bits
    function automatic logic [127:0] aes_round(input logic [127:0] lane);
        logic [7:0] sr [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] res;
        res = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sr[r + 4*c] = SBOX[lane[8*(r + 4*((c + r) % 4)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = sr[4*c]; a1 = sr[4*c+1]; a2 = sr[4*c+2]; a3 = sr[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            res[8*(4*c)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            res[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            res[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            res[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        aes_round = res;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/a256x2_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// a256x2_round
// Next state for an update: twelve parallel AES lane rounds plus XORs.
// ----------------------------------------------------------------------------
module a256x2_round (
    input  wire a256x2_pkg::t_word i_state [a256x2_pkg::NUM_WORDS],
    input  wire a256x2_pkg::t_word i_msg   [4],
    output a256x2_pkg::t_word      o_state [a256x2_pkg::NUM_WORDS]
);
    import a256x2_pkg::*;

    always_comb begin
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            for (int l = 0; l < 2; l++) begin
                logic [127:0] rl;
                int p;
                p  = (b == 0) ? NUM_BLOCKS - 1 : b - 1;
                rl = aes_round({i_state[4*p + 2*l + 1], i_state[4*p + 2*l]});
                o_state[4*b + 2*l]     = rl[63:0]   ^ i_state[4*b + 2*l]
                                         ^ ((b == 0) ? i_msg[2*l] : 64'd0);
                o_state[4*b + 2*l + 1] = rl[127:64] ^ i_state[4*b + 2*l + 1]
                                         ^ ((b == 0) ? i_msg[2*l + 1] : 64'd0);
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/aegis256x2_state_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aegis256x2_state_update
// AEGIS-256X2 state register with word access and full-round update.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one request word: write a state
//   word, read a state word, or absorb a 256-bit message block. Kind 3 is
//   dropped without a result. Output channel (o_valid/i_ready) returns one
//   word per request: read data (zero unless a valid read) and the kind.
//   The result appears in the cycle after acceptance.
//   Throughput: one request per cycle while results are taken. The update,
//   a full combinational round of all twelve AES lanes, sets the clock path.
//   The state updates at acceptance, so a following request sees it.
//   Stall: while a result waits and i_ready is low, o_ready drops; it rises
//   again in the cycle the result is taken.
//   Reset: state cleared to zero, output register empty.
// ----------------------------------------------------------------------------
module aegis256x2_state_update (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_req_type,
    input  wire  [4:0]  i_word_index,
    input  wire  [63:0] i_word_value,
    input  wire  [63:0] i_msg_word0,
    input  wire  [63:0] i_msg_word1,
    input  wire  [63:0] i_msg_word2,
    input  wire  [63:0] i_msg_word3,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [63:0] o_read_data,
    output logic [1:0]  o_done_type
);
    import a256x2_pkg::*;

    t_word r_state [NUM_WORDS];
    t_word n_state [NUM_WORDS];
    t_word w_msg   [4];
    t_word r_rd;
    logic [1:0] r_type;
    logic r_valid;
    logic w_acc;
    logic w_inr;

    assign w_msg[0] = i_msg_word0;
    assign w_msg[1] = i_msg_word1;
    assign w_msg[2] = i_msg_word2;
    assign w_msg[3] = i_msg_word3;

    a256x2_round u_round (
        .i_state (r_state),
        .i_msg   (w_msg),
        .o_state (n_state)
    );

    assign o_ready = !r_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_inr   = i_word_index < 5'(NUM_WORDS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WORDS; k++) r_state[k] <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (w_acc && i_req_type != REQ_NONE) || (r_valid && !i_ready);
            if (w_acc && i_req_type != REQ_NONE) begin
                r_type  <= i_req_type;
                r_rd    <= '0;
                case (i_req_type)
                    REQ_WRITE: begin
                        if (w_inr) r_state[i_word_index] <= i_word_value;
                    end
                    REQ_READ: begin
                        if (w_inr) r_rd <= r_state[i_word_index];
                    end
                    REQ_UPDATE: begin
                        r_state <= n_state;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_read_data = r_rd;
    assign o_done_type = r_type;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data)) else $error("result lost");
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_req_type == REQ_NONE && !(o_valid && i_ready) && !o_valid |=> !o_valid)
        else $error("kind 3 made a result");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_req_type != REQ_READ && i_req_type != REQ_NONE |=> o_read_data == 64'd0)
        else $error("nonzero data for non-read");

endmodule
`default_nettype wire

// ===== tb/sv/tb_aegis256x2_state_update.sv =====
// ----------------------------------------------------------------------------
// tb_aegis256x2_state_update
// Drives word writes, reads, message updates and dropped kind-3 requests into
// the AEGIS-256X2 state block with random idling on both sides. A local
// model of the six-block state predicts each returned word, compared by field.
// ----------------------------------------------------------------------------
module tb_aegis256x2_state_update;
    import a256x2_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_DIRECTED     = 14;
    localparam int N_RANDOM       = 1800;

    typedef struct {
        logic [1:0]  kind;
        logic [4:0]  idx;
        logic [63:0] value;
        logic [63:0] msg [4];
    } t_req;

    typedef struct {
        logic [63:0] data;
        logic [1:0]  kind;
    } t_done;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_req_type;
    logic [4:0]  i_word_index;
    logic [63:0] i_word_value;
    logic [63:0] i_msg_word0;
    logic [63:0] i_msg_word1;
    logic [63:0] i_msg_word2;
    logic [63:0] i_msg_word3;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_read_data;
    logic [1:0]  o_done_type;

    aegis256x2_state_update DUT (.*);

    logic [63:0] model_state [NUM_WORDS];
    t_done       done_queue [$];
    int          n_errors;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] lane_round(input logic [127:0] lane);
        logic [7:0]   s [16];
        logic [7:0]   b0, b1, b2, b3, mix;
        logic [127:0] r;
        r = '0;
        for (int c = 0; c < 4; c++)
            for (int row = 0; row < 4; row++)
                s[row + 4*c] = SBOX[lane[8*(row + 4*((c + row) & 3)) +: 8]];
        for (int c = 0; c < 4; c++) begin
            b0 = s[4*c]; b1 = s[4*c+1]; b2 = s[4*c+2]; b3 = s[4*c+3];
            mix = b0 ^ b1 ^ b2 ^ b3;
            r[32*c      +: 8] = b0 ^ mix ^ gf_double(b0 ^ b1);
            r[32*c + 8  +: 8] = b1 ^ mix ^ gf_double(b1 ^ b2);
            r[32*c + 16 +: 8] = b2 ^ mix ^ gf_double(b2 ^ b3);
            r[32*c + 24 +: 8] = b3 ^ mix ^ gf_double(b3 ^ b0);
        end
        return r;
    endfunction

    function automatic void absorb_message(input t_req q);
        logic [63:0]  old [NUM_WORDS];
        logic [127:0] l0, l1;
        int           p;
        old = model_state;
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            p  = (b == 0) ? NUM_BLOCKS - 1 : b - 1;
            l0 = lane_round({old[4*p+1], old[4*p]});
            l1 = lane_round({old[4*p+3], old[4*p+2]});
            model_state[4*b]   = l0[63:0]    ^ old[4*b];
            model_state[4*b+1] = l0[127:64]  ^ old[4*b+1];
            model_state[4*b+2] = l1[63:0]    ^ old[4*b+2];
            model_state[4*b+3] = l1[127:64]  ^ old[4*b+3];
        end
        for (int w = 0; w < 4; w++) model_state[w] ^= q.msg[w];
    endfunction

    function automatic void predict_done(input t_req q);
        t_done d;
        if (q.kind == REQ_NONE) return;
        d.data = '0;
        d.kind = q.kind;
        if (q.kind == REQ_WRITE) begin
            if (q.idx < NUM_WORDS) model_state[q.idx] = q.value;
        end else if (q.kind == REQ_READ) begin
            if (q.idx < NUM_WORDS) d.data = model_state[q.idx];
        end else begin
            absorb_message(q);
        end
        done_queue.push_back(d);
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_req random_req();
        t_req q;
        int   k;
        k = $urandom_range(0, 99);
        q.kind = (k < 35) ? REQ_WRITE : (k < 65) ? REQ_READ : (k < 95) ? REQ_UPDATE : REQ_NONE;
        q.idx   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                              : 5'($urandom_range(0, 23));
        q.value = rand64();
        for (int w = 0; w < 4; w++) q.msg[w] = rand64();
        return q;
    endfunction

    task automatic send_req(input t_req q);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= q.kind;
        i_word_index <= q.idx;
        i_word_value <= q.value;
        i_msg_word0  <= q.msg[0];
        i_msg_word1  <= q.msg[1];
        i_msg_word2  <= q.msg[2];
        i_msg_word3  <= q.msg[3];
        do @(posedge i_clk); while (!o_ready);
        predict_done(q);
    endtask

    // receiver side and result check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (done_queue.size() == 0) begin
                    $display("%0t: unexpected result data=%h kind=%0d",
                             $time, o_read_data, o_done_type);
                    n_errors++;
                end else begin
                    if (o_read_data !== done_queue[0].data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, done_queue[0].data, o_read_data);
                        n_errors++;
                    end
                    if (o_done_type !== done_queue[0].kind) begin
                        $display("%0t: done_type expected %0d actual %0d",
                                 $time, done_queue[0].kind, o_done_type);
                        n_errors++;
                    end
                    void'(done_queue.pop_front());
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_aegis256x2_state_update NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    t_req directed [N_DIRECTED];
    logic [63:0] directed_data [N_DIRECTED];
    logic        directed_known [N_DIRECTED];

    function automatic t_req mk(input logic [1:0] k, input logic [4:0] ix,
                                input logic [63:0] v, input logic [63:0] m);
        t_req q;
        q.kind = k; q.idx = ix; q.value = v;
        for (int w = 0; w < 4; w++) q.msg[w] = m ^ 64'(w);
        return q;
    endfunction

    initial begin
        t_req q;
        n_errors = 0; idle_cycles = 0;
        send_idle_pct = 23; recv_idle_pct = 48;
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0;
        i_req_type = REQ_WRITE; i_word_index = '0; i_word_value = '0;
        i_msg_word0 = '0; i_msg_word1 = '0; i_msg_word2 = '0; i_msg_word3 = '0;
        for (int i = 0; i < NUM_WORDS; i++) model_state[i] = '0;

        // kind, index, value, message seed; known read result where obvious
        directed[0]  = mk(REQ_READ,   5'd0,  '1, '1);   // zero after reset
        directed[1]  = mk(REQ_READ,   5'd23, '0, '0);   // zero after reset
        directed[2]  = mk(REQ_WRITE,  5'd0,  '1, '0);
        directed[3]  = mk(REQ_READ,   5'd0,  '0, '0);   // all ones
        directed[4]  = mk(REQ_WRITE,  5'd23, 64'h8000_0000_0000_0001, '1);
        directed[5]  = mk(REQ_READ,   5'd23, '0, '0);
        directed[6]  = mk(REQ_WRITE,  5'd31, '1, '0);   // out of range write
        directed[7]  = mk(REQ_READ,   5'd31, '0, '0);   // out of range read
        directed[8]  = mk(REQ_NONE,   5'd1,  '1, '1);   // dropped
        directed[9]  = mk(REQ_UPDATE, 5'd3,  '1, '1);
        directed[10] = mk(REQ_UPDATE, 5'd0,  '0, '0);
        directed[11] = mk(REQ_READ,   5'd0,  '0, '0);
        directed[12] = mk(REQ_READ,   5'd12, '0, '0);
        directed[13] = mk(REQ_READ,   5'd22, '0, '0);
        for (int i = 0; i < N_DIRECTED; i++) directed_known[i] = 1'b0;
        directed_known[0] = 1'b1; directed_data[0] = '0;
        directed_known[1] = 1'b1; directed_data[1] = '0;
        directed_known[3] = 1'b1; directed_data[3] = '1;
        directed_known[5] = 1'b1; directed_data[5] = 64'h8000_0000_0000_0001;
        directed_known[7] = 1'b1; directed_data[7] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_req(directed[i]);
            if (directed_known[i] && done_queue.size() != 0 &&
                done_queue[$].data !== directed_data[i]) begin
                $display("%0t: row %0d expected %h actual %h",
                         $time, i, directed_data[i], done_queue[$].data);
                n_errors++;
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 48 : 0;
            recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 23 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                q = random_req();
                send_req(q);
            end
        end
        i_valid <= 1'b0;

        while (done_queue.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (n_errors == 0 && done_queue.size() == 0) begin
            $display("tb_aegis256x2_state_update OK");
        end else begin
            $display("tb_aegis256x2_state_update NOT OK");
        end
        $finish;
    end
endmodule
